// ===== rtl/core/hbtm_pkg.sv =====
package hbtm_pkg;

  localparam int NODE_COUNT = 8;
  localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int COUNT_W    = $clog2(NODE_COUNT + 1);
  localparam int MISSED_W   = 3;
  localparam int TICKS_W    = 16;
  localparam int NODE_ID_W  = 8;
  localparam int MASK_W     = 8;
  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_HEARTBEAT = 2'd1,
    ACT_DRAIN     = 2'd2,
    ACT_START     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_SELF_NODE     = 2'd0,
    REG_DISABLED_MASK = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic empty;
    logic lost;
  } fifo_stat_t;

  function automatic logic is_monitored(input logic [NODE_ID_W-1:0] node,
                                        input logic [NODE_ID_W-1:0] self_id,
                                        input logic [MASK_W-1:0]    mask);
    logic mon;
    mon = 1'b1;
    if (int'(node) >= NODE_COUNT) mon = 1'b0;
    if (node == self_id) mon = 1'b0;
    if ((int'(node) < MASK_W) && mask[node[2:0]]) mon = 1'b0;
    return mon;
  endfunction

endpackage

// ===== rtl/core/hbtm_cell.sv =====
module hbtm_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hbtm_pkg::cell_ctrl_t          ctrl,
  input  logic [hbtm_pkg::TICKS_W-1:0]  timeout,
  input  logic                          miss_in,
  output logic                          miss_out
);

  logic [hbtm_pkg::TICKS_W-1:0] remaining_r, remaining_nxt;
  logic                         armed_r, armed_nxt;
  logic                         miss_r, miss_nxt;

  always_comb begin
    remaining_nxt = remaining_r;
    armed_nxt     = armed_r;
    miss_nxt      = miss_r;
    if (ctrl.shift) begin
      miss_nxt = miss_in;
    end
    if (ctrl.tick && armed_r) begin
      if (remaining_r <= hbtm_pkg::TICKS_W'(1)) begin
        remaining_nxt = '0;
        armed_nxt     = 1'b0;
        miss_nxt      = 1'b1;
      end else begin
        remaining_nxt = remaining_r - hbtm_pkg::TICKS_W'(1);
      end
    end
    if (ctrl.load) begin
      armed_nxt     = 1'b1;
      remaining_nxt = timeout;
    end else if (ctrl.clear) begin
      armed_nxt     = 1'b0;
      remaining_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      armed_r     <= 1'b0;
      miss_r      <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      armed_r     <= armed_nxt;
      miss_r      <= miss_nxt;
    end
  end

  assign miss_out = miss_r;

endmodule

// ===== rtl/core/hbtm_fifo.sv =====
module hbtm_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [hbtm_pkg::MISSED_W-1:0]  push_node,
  input  logic                           pop,
  output logic [hbtm_pkg::MISSED_W-1:0]  head_node,
  output hbtm_pkg::fifo_stat_t           stat
);

  logic [hbtm_pkg::MISSED_W-1:0] mem_r [hbtm_pkg::NODE_COUNT];
  logic [hbtm_pkg::MISSED_W-1:0] head_data_r;
  logic [hbtm_pkg::NODE_W-1:0]   head_r, head_nxt;
  logic [hbtm_pkg::NODE_W-1:0]   tail_r, tail_nxt;
  logic [hbtm_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                          lost_r, lost_nxt;
  logic                          empty, full, do_push, do_pop;

  localparam logic [hbtm_pkg::NODE_W-1:0] LAST_PTR =
    hbtm_pkg::NODE_W'(hbtm_pkg::NODE_COUNT - 1);
  localparam logic [hbtm_pkg::COUNT_W-1:0] FULL_COUNT =
    hbtm_pkg::COUNT_W'(hbtm_pkg::NODE_COUNT);

  assign empty   = (count_r == '0);
  assign full    = (count_r == FULL_COUNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    lost_nxt  = lost_r;
    if (do_push) begin
      tail_nxt  = (tail_r == LAST_PTR) ? '0 : tail_r + hbtm_pkg::NODE_W'(1);
      count_nxt = count_r + hbtm_pkg::COUNT_W'(1);
    end
    if (push && full) begin
      lost_nxt = 1'b1;
    end
    if (do_pop) begin
      head_nxt  = (head_r == LAST_PTR) ? '0 : head_r + hbtm_pkg::NODE_W'(1);
      count_nxt = count_r - hbtm_pkg::COUNT_W'(1);
      lost_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      lost_r  <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      lost_r  <= lost_nxt;
    end
  end

  // prefetch the next head entry, bypassing a write to that slot
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail_r] <= push_node;
    end
    if (do_push && (tail_r == head_nxt)) begin
      head_data_r <= push_node;
    end else begin
      head_data_r <= mem_r[head_nxt];
    end
  end

  assign head_node  = head_data_r;
  assign stat.empty = empty;
  assign stat.lost  = lost_r;

endmodule

// ===== rtl/core/heartbeat_timeout_monitor.sv =====
// Heartbeat timeout monitor: one one-shot timer per node in a row of cells.
// Input channel (in_*): in_tuser carries the action (tick, heartbeat, drain,
// start), in_tdata the heartbeat sender. A start arms every monitored node
// with timeout_ticks and disarms the rest; a heartbeat re-arms its sender if
// that node is monitored; a tick counts all armed timers down at once.
// Nodes that expire on a tick raise a miss bit in their cell; the miss bits
// then shift one cell a cycle towards node 0, which pushes them into the
// missed-node FIFO lowest index first. in_tready stays low while bits are
// still shifting, so after a tick the next item waits until the highest
// expired bit has been pushed; other items stall only on full output stages.
// Result channel (out_*): a drain that finds the FIFO non-empty gives one
// item, registered. An output register and a one-item skid stage let the
// block take further items while a result waits; with both full in_tready
// drops until out_tready takes one.
// Configuration (cfg_*) is written any time and is always ready.
// Reset (rst_n low, synchronous) disarms all timers, empties the FIFO and
// output stages, and loads self_node 0, disabled_mask 0, timeout 1000.
module heartbeat_timeout_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_node
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] missed_node, [3] reports_lost, [7:4] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N  = hbtm_pkg::NODE_COUNT;
  localparam int RW = hbtm_pkg::MISSED_W + 1;

  logic [hbtm_pkg::NODE_ID_W-1:0] self_node_r;
  logic [hbtm_pkg::MASK_W-1:0]    disabled_mask_r;
  logic [hbtm_pkg::TICKS_W-1:0]   timeout_ticks_r;

  logic [hbtm_pkg::NODE_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [RW-1:0]                  out_data_r, out_data_nxt;
  logic                           skid_valid_r, skid_valid_nxt;
  logic [RW-1:0]                  skid_data_r, skid_data_nxt;

  hbtm_pkg::action_t              action;
  hbtm_pkg::cell_ctrl_t           ctrl [N];
  hbtm_pkg::fifo_stat_t           fifo_stat;
  logic [N-1:0]                   miss_v;
  logic [N-1:0]                   chain_in;
  logic                           busy, accept, push, pop, take, new_res, src_mon;
  logic [hbtm_pkg::MISSED_W-1:0]  head_node;
  logic [RW-1:0]                  new_data;

  assign action    = hbtm_pkg::action_t'(in_tuser);
  assign busy      = |miss_v;
  assign in_tready = !busy && !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign src_mon   = hbtm_pkg::is_monitored(in_tdata, self_node_r, disabled_mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_node_r     <= '0;
      disabled_mask_r <= '0;
      timeout_ticks_r <= hbtm_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hbtm_pkg::REG_SELF_NODE:     self_node_r     <= cfg_data[7:0];
        hbtm_pkg::REG_DISABLED_MASK: disabled_mask_r <= cfg_data[7:0];
        hbtm_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign chain_in = {1'b0, miss_v[N-1:1]};

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic mon_i;
    assign mon_i = hbtm_pkg::is_monitored(hbtm_pkg::NODE_ID_W'(i), self_node_r,
                                          disabled_mask_r);
    assign ctrl[i].tick  = accept && (action == hbtm_pkg::ACT_TICK);
    assign ctrl[i].load  = (accept && (action == hbtm_pkg::ACT_HEARTBEAT) && src_mon &&
                            (in_tdata == hbtm_pkg::NODE_ID_W'(i))) ||
                           (accept && (action == hbtm_pkg::ACT_START) && mon_i);
    assign ctrl[i].clear = accept && (action == hbtm_pkg::ACT_START) && !mon_i;
    assign ctrl[i].shift = busy;

    hbtm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[i]),
      .timeout  (timeout_ticks_r),
      .miss_in  (chain_in[i]),
      .miss_out (miss_v[i])
    );
  end

  // Node index of the bit now in cell 0
  always_comb begin
    scan_cnt_nxt = scan_cnt_r;
    if (accept && (action == hbtm_pkg::ACT_TICK)) begin
      scan_cnt_nxt = '0;
    end else if (busy) begin
      scan_cnt_nxt = scan_cnt_r + hbtm_pkg::NODE_W'(1);
    end
  end

  assign push = busy && miss_v[0];
  assign pop  = accept && (action == hbtm_pkg::ACT_DRAIN);

  hbtm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_node (hbtm_pkg::MISSED_W'(scan_cnt_r)),
    .pop       (pop),
    .head_node (head_node),
    .stat      (fifo_stat)
  );

  assign new_res  = pop && !fifo_stat.empty;
  assign new_data = {fifo_stat.lost, head_node};
  assign take     = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (new_res) begin
        out_data_nxt = new_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (new_res) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = new_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = new_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      scan_cnt_r   <= scan_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(8 - RW)'(0), out_data_r};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while the output register is empty");

  a_drain_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (action == hbtm_pkg::ACT_DRAIN) && !fifo_stat.empty) |=> out_valid_r)
    else $error("drain of a non-empty FIFO produced no result");

  a_push_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !in_tready)
    else $error("missed-node push while input is accepted");

endmodule

// ===== sim/tb_heartbeat_timeout_monitor.sv =====
module tb_heartbeat_timeout_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [hbtm_pkg::MISSED_W-1:0] node;
    logic                          lost;
  } report_t;

  typedef struct packed {
    hbtm_pkg::action_t             act;
    logic [7:0]                    src;
    logic                          typed;
    logic [hbtm_pkg::MISSED_W-1:0] node;
    logic                          lost;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_HEARTBEAT, 8'd255, 1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_HEARTBEAT, 8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_HEARTBEAT, 8'd8,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_TICK,      8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_HEARTBEAT, 8'd5,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_TICK,      8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd5, 1'b0},
    '{hbtm_pkg::ACT_START,     8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_TICK,      8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_START,     8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_TICK,      8'd0,   1'b0, 3'd0, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd1, 1'b1},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd2, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd3, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd4, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd5, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd6, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd7, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b1, 3'd1, 1'b0},
    '{hbtm_pkg::ACT_DRAIN,     8'd0,   1'b0, 3'd0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  heartbeat_timeout_monitor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // monitor copy
  logic [hbtm_pkg::NODE_ID_W-1:0] mon_self;
  logic [hbtm_pkg::MASK_W-1:0]    mon_mask;
  logic [hbtm_pkg::TICKS_W-1:0]   mon_timeout;
  logic [hbtm_pkg::TICKS_W-1:0]   ticks_left [hbtm_pkg::NODE_COUNT];
  bit                             armed [hbtm_pkg::NODE_COUNT];
  logic [hbtm_pkg::MISSED_W-1:0]  missed_q [hbtm_pkg::NODE_COUNT];
  int                             missed_head;
  int                             missed_count;
  bit                             lost_pending;

  report_t reports_due [$];

  int send_pct;
  int recv_pct;
  int errors;
  int items_sent;
  int reports_seen;
  int lost_seen;
  int cfg_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk)
    out_tready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);

  task automatic flag_error(input string msg);
    if (errors < 10)
      $display("%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (out_tdata[3])
        lost_seen++;
      if (reports_due.size() == 0) begin
        flag_error($sformatf("unexpected report node %0d lost %0d",
                             out_tdata[2:0], out_tdata[3]));
      end else begin
        want = reports_due.pop_front();
        if (out_tdata[2:0] !== want.node)
          flag_error($sformatf("missed_node exp %0d got %0d", want.node, out_tdata[2:0]));
        if (out_tdata[3] !== want.lost)
          flag_error($sformatf("reports_lost exp %0d got %0d", want.lost, out_tdata[3]));
        if (out_tdata[7:4] !== 4'd0)
          flag_error($sformatf("padding exp 0 got %h", out_tdata[7:4]));
      end
    end
  end

  function automatic bit watched(input int n);
    if (n >= hbtm_pkg::NODE_COUNT) return 1'b0;
    if (n == int'(mon_self)) return 1'b0;
    if (n < hbtm_pkg::MASK_W && mon_mask[n]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic record_miss(input int n);
    if (missed_count >= hbtm_pkg::NODE_COUNT) begin
      lost_pending = 1'b1;
    end else begin
      missed_q[(missed_head + missed_count) % hbtm_pkg::NODE_COUNT] =
        hbtm_pkg::MISSED_W'(n);
      missed_count++;
    end
  endtask

  task automatic advance_monitor(input hbtm_pkg::action_t act, input logic [7:0] src,
                                 output bit has_report, output report_t rep);
    has_report = 1'b0;
    rep = '0;
    case (act)
      hbtm_pkg::ACT_TICK: begin
        for (int n = 0; n < hbtm_pkg::NODE_COUNT; n++) begin
          if (armed[n]) begin
            if (ticks_left[n] <= 1) begin
              ticks_left[n] = '0;
              armed[n] = 1'b0;
              record_miss(n);
            end else begin
              ticks_left[n] = ticks_left[n] - 1'b1;
            end
          end
        end
      end
      hbtm_pkg::ACT_HEARTBEAT: begin
        if (watched(int'(src))) begin
          armed[src[hbtm_pkg::NODE_W-1:0]] = 1'b1;
          ticks_left[src[hbtm_pkg::NODE_W-1:0]] = mon_timeout;
        end
      end
      hbtm_pkg::ACT_DRAIN: begin
        if (missed_count != 0) begin
          has_report = 1'b1;
          rep.node = missed_q[missed_head];
          rep.lost = lost_pending;
          missed_head = (missed_head + 1) % hbtm_pkg::NODE_COUNT;
          missed_count--;
          lost_pending = 1'b0;
        end
      end
      default: begin
        for (int n = 0; n < hbtm_pkg::NODE_COUNT; n++) begin
          armed[n] = watched(n);
          ticks_left[n] = watched(n) ? mon_timeout : '0;
        end
      end
    endcase
  endtask

  // call at a falling edge; returns at a falling edge with in_tvalid still high
  task automatic send_item(input hbtm_pkg::action_t act, input logic [7:0] src,
                           input bit typed, input report_t typed_rep);
    bit      has_report;
    report_t rep;
    while ((send_pct != 0) && ($urandom_range(99) < send_pct)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= src;
    do @(posedge clk); while (!in_tready);
    advance_monitor(act, src, has_report, rep);
    if (has_report)
      reports_due.push_back(typed ? typed_rep : rep);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hbtm_pkg::REG_SELF_NODE:     mon_self = val[hbtm_pkg::NODE_ID_W-1:0];
      hbtm_pkg::REG_DISABLED_MASK: mon_mask = val[hbtm_pkg::MASK_W-1:0];
      hbtm_pkg::REG_TIMEOUT_TICKS: mon_timeout = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic drain_out();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] self_id, input logic [7:0] mask,
                           input logic [15:0] ticks);
    drain_out();
    write_reg(hbtm_pkg::REG_SELF_NODE, {8'd0, self_id});
    write_reg(hbtm_pkg::REG_DISABLED_MASK, {8'd0, mask});
    write_reg(hbtm_pkg::REG_TIMEOUT_TICKS, ticks);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int count, input int pause_at);
    int                r;
    hbtm_pkg::action_t act;
    logic [7:0]        src;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        // hold off until every report is out
        in_tvalid <= 1'b0;
        do @(negedge clk); while (reports_due.size() != 0);
      end
      r = $urandom_range(99);
      src = 8'($urandom_range(255));
      if (r < 40)
        act = hbtm_pkg::ACT_TICK;
      else if (r < 65) begin
        act = hbtm_pkg::ACT_HEARTBEAT;
        if ($urandom_range(4) != 0)
          src = 8'($urandom_range(hbtm_pkg::NODE_COUNT - 1));
      end else if (r < 90)
        act = hbtm_pkg::ACT_DRAIN;
      else
        act = hbtm_pkg::ACT_START;
      send_item(act, src, 1'b0, '0);
    end
  endtask

  initial begin
    send_pct = 0;
    recv_pct = 0;
    errors = 0;
    items_sent = 0;
    reports_seen = 0;
    lost_seen = 0;
    cfg_writes = 0;
    mon_self = '0;
    mon_mask = '0;
    mon_timeout = hbtm_pkg::TIMEOUT_RESET;
    for (int n = 0; n < hbtm_pkg::NODE_COUNT; n++) begin
      ticks_left[n] = '0;
      armed[n] = 1'b0;
      missed_q[n] = '0;
    end
    missed_head = 0;
    missed_count = 0;
    lost_pending = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(hbtm_pkg::REG_TIMEOUT_TICKS, 16'd1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIR_TAB[i].act, DIR_TAB[i].src, DIR_TAB[i].typed,
                '{node: DIR_TAB[i].node, lost: DIR_TAB[i].lost});

    configure(8'd7, 8'h00, 16'd2);
    random_items(250, -1);

    configure(8'd255, 8'h24, 16'd0);
    send_pct = 86;
    random_items(250, -1);

    configure(8'd4, 8'h81, 16'd5);
    send_pct = 0;
    recv_pct = 86;
    random_items(250, 125);

    configure(8'd0, 8'hFF, 16'hFFFF);
    send_pct = 30;
    recv_pct = 30;
    random_items(100, -1);

    configure(8'($urandom_range(9)), 8'($urandom_range(255)),
              16'($urandom_range(1, 6)));
    random_items(250, -1);

    configure(8'd1, 8'h40, 16'd3);
    send_pct = 0;
    recv_pct = 0;
    random_items(150, -1);

    drain_out();
    $display("Covered %0d items and %0d register writes over four idling patterns;",
             items_sent, cfg_writes);
    $display("%0d reports checked, %0d of them with the lost flag set.",
             reports_seen, lost_seen);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hbtm_pkg.sv
rtl/core/hbtm_cell.sv
rtl/core/hbtm_fifo.sv
rtl/core/heartbeat_timeout_monitor.sv
sim/tb_heartbeat_timeout_monitor.sv
